[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge of clock.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/glu_pkg.sv]
// ----------------------------------------------------------------------------
// Glyph lookup package
// Types and constants shared by the UTF-8 glyph lookup block.
// ----------------------------------------------------------------------------
package glu_pkg;

   localparam int MAX_GLYPHS = 1024;
   localparam int SLOT_W     = $clog2(MAX_GLYPHS);
   localparam int COUNT_W    = 11;
   localparam int CODE_W     = 16;
   localparam int WIDTH_W    = 8;
   localparam int ENTRY_W    = CODE_W + WIDTH_W;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   localparam logic [1:0] LEN_ONE   = 2'd1;
   localparam logic [1:0] LEN_TWO   = 2'd2;
   localparam logic [1:0] LEN_THREE = 2'd3;

   localparam logic [CODE_W-1:0]         QMARK_CODE      = 16'h003F;
   localparam logic [CODE_W-1:0]         SPACE_CODE      = 16'h0020;
   localparam logic [CODE_W-1:0]         SPECIAL_LIMIT   = 16'd8;
   localparam logic signed [WIDTH_W-1:0] SPECIAL_ADVANCE = 8'sd10;

   typedef struct packed {
      logic                      kind;
      logic [9:0]                entry_slot;
      logic [CODE_W-1:0]         entry_code;
      logic signed [WIDTH_W-1:0] entry_width;
      logic [7:0]                byte_first;
      logic [7:0]                byte_second;
      logic [7:0]                byte_third;
   } req_type;

   typedef struct packed {
      logic                      found;
      logic [9:0]                glyph_slot;
      logic signed [WIDTH_W-1:0] advance;
      logic [CODE_W-1:0]         code_point;
      logic [1:0]                seq_length;
   } rsp_type;

   typedef struct packed {
      logic [CODE_W-1:0] code_point;
      logic [1:0]        seq_length;
   } decode_type;

   typedef struct packed {
      logic [CODE_W-1:0]         entry_code;
      logic signed [WIDTH_W-1:0] entry_width;
   } entry_type;

endpackage

[src/glu_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module glu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/glu_decode.sv]
// ----------------------------------------------------------------------------
// UTF-8 decoder
// Turns up to three UTF-8 bytes into a 16-bit code point and a length.
// ----------------------------------------------------------------------------
module glu_decode import glu_pkg::*; (
   input  logic [7:0]  byte_first,
   input  logic [7:0]  byte_second,
   input  logic [7:0]  byte_third,
   output decode_type  dec
);

   logic second_cont;
   logic third_cont;

   assign second_cont = (byte_second[7:6] == 2'b10);
   assign third_cont  = (byte_third[7:6] == 2'b10);

   always_comb begin
      dec.code_point = QMARK_CODE;
      dec.seq_length = LEN_ONE;
      priority if (!byte_first[7]) begin
         dec.code_point = {8'd0, byte_first};
         dec.seq_length = LEN_ONE;
      end else if (byte_first[7:5] == 3'b110 && second_cont) begin
         dec.code_point = {5'd0, byte_first[4:0], byte_second[5:0]};
         dec.seq_length = LEN_TWO;
      end else if (byte_first[7:4] == 4'b1110 && second_cont && third_cont) begin
         dec.code_point = {byte_first[3:0], byte_second[5:0], byte_third[5:0]};
         dec.seq_length = LEN_THREE;
      end else begin
         dec.code_point = QMARK_CODE;
         dec.seq_length = LEN_ONE;
      end
   end

endmodule

[src/utf8_glyph_lookup.sv]
// ----------------------------------------------------------------------------
// UTF-8 glyph lookup
// Decodes a UTF-8 character and binary-searches a sorted glyph table.
// ----------------------------------------------------------------------------
// A write item stores one table entry in the cycle it is accepted and gives no
// result. A lookup item decodes its bytes, then searches the first
// glyph_count entries, one probe per cycle through the read port of the table
// RAM, with a second search for '?' on a miss above space. Each search opens
// with a setup state, ST_SEEK, and then probes the table in ST_PROBE. The
// result is shown on rsp_item for exactly one cycle with rsp_valid high and
// cannot be held off; busy falls in that same cycle, so the next item may
// start at once.
module utf8_glyph_lookup import glu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_item,
   output logic               rsp_valid,
   output rsp_type            rsp_item,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SEEK  = 3'b010,
      ST_PROBE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_eff;
   logic [COUNT_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [SLOT_W-1:0]  mid_ff, mid_in;
   logic [CODE_W-1:0]  key_ff, key_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic [1:0]         len_ff, len_in;
   logic               qpass_ff, qpass_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   decode_type         dec;
   entry_type          wr_entry, rd_entry;
   logic               wr_en, rd_en;
   logic [SLOT_W-1:0]  rd_addr;
   logic               accept;

   logic [COUNT_W-1:0] probe_lo, probe_hi, cur_lo, cur_hi;
   logic [COUNT_W:0]   mid_sum;
   logic               range_open;
   logic               probe_hit;
   logic               second_search;

   glu_decode u_glu_decode (
      .byte_first  (req_item.byte_first),
      .byte_second (req_item.byte_second),
      .byte_third  (req_item.byte_third),
      .dec         (dec)
   );

   assign wr_entry.entry_code  = req_item.entry_code;
   assign wr_entry.entry_width = req_item.entry_width;

   glu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_GLYPHS)
   ) u_glu_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_item.entry_slot[SLOT_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign wr_en     = accept && (req_item.kind == KIND_WRITE);
   assign csr_ready = 1'b1;
   assign count_eff = (count_ff > COUNT_W'(MAX_GLYPHS)) ? COUNT_W'(MAX_GLYPHS) : count_ff;

   assign probe_hit = (key_ff == rd_entry.entry_code);
   assign probe_lo  = (key_ff > rd_entry.entry_code) ? COUNT_W'(mid_ff) + 1'b1 : lo_ff;
   assign probe_hi  = (key_ff < rd_entry.entry_code) ? COUNT_W'(mid_ff) : hi_ff;
   assign cur_lo    = (state_ff == ST_PROBE) ? probe_lo : lo_ff;
   assign cur_hi    = (state_ff == ST_PROBE) ? probe_hi : hi_ff;
   assign range_open = (cur_lo < cur_hi);
   assign mid_sum   = {1'b0, cur_lo} + {1'b0, cur_hi} - 1'b1;
   assign rd_addr   = mid_sum[SLOT_W:1];
   assign second_search = (code_ff > SPACE_CODE) && !qpass_ff;

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      code_in      = code_ff;
      len_in       = len_ff;
      qpass_in     = qpass_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_item.kind == KIND_LOOKUP) begin
               code_in  = dec.code_point;
               key_in   = dec.code_point;
               len_in   = dec.seq_length;
               lo_in    = '0;
               hi_in    = count_eff;
               qpass_in = 1'b0;
               state_in = ST_SEEK;
            end
         end
         ST_SEEK, ST_PROBE: begin
            if (state_ff == ST_PROBE && probe_hit) begin
               rsp_valid_in       = 1'b1;
               rsp_in.found       = 1'b1;
               rsp_in.glyph_slot  = mid_ff;
               rsp_in.advance     = rd_entry.entry_width;
               rsp_in.code_point  = code_ff;
               rsp_in.seq_length  = len_ff;
               state_in           = ST_IDLE;
            end else if (range_open) begin
               rd_en    = 1'b1;
               lo_in    = cur_lo;
               hi_in    = cur_hi;
               mid_in   = rd_addr;
               state_in = ST_PROBE;
            end else if (second_search) begin
               key_in   = QMARK_CODE;
               qpass_in = 1'b1;
               lo_in    = '0;
               hi_in    = count_eff;
               state_in = ST_SEEK;
            end else begin
               rsp_valid_in      = 1'b1;
               rsp_in.found      = 1'b0;
               rsp_in.glyph_slot = '0;
               rsp_in.advance    = (code_ff != '0 && code_ff < SPECIAL_LIMIT) ?
                                   SPECIAL_ADVANCE : '0;
               rsp_in.code_point = code_ff;
               rsp_in.seq_length = len_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      key_ff   <= key_in;
      code_ff  <= code_in;
      len_ff   <= len_in;
      qpass_ff <= qpass_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[src/glu_checker.sv]
// ----------------------------------------------------------------------------
// Glyph lookup checker
// Port-level assertions on the UTF-8 glyph lookup block, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glu_checker import glu_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   `ASSERT_CLK(a_lookup_goes_busy, (start && !busy && req_item.kind == KIND_LOOKUP) |=> busy, "lookup item did not raise busy")
   `ASSERT_CLK(a_write_no_result, (start && !busy && req_item.kind == KIND_WRITE) |=> (!busy && !rsp_valid), "write item caused work or a result")
   `ASSERT_CLK(a_single_strobe, rsp_valid |=> !rsp_valid, "result strobe lasted more than one cycle")
   `ASSERT_CLK(a_miss_slot_zero, (rsp_valid && !rsp_item.found) |-> (rsp_item.glyph_slot == '0), "miss reported a nonzero slot")
   `ASSERT_ALWAYS(a_reset_quiet, $past(reset) |-> (!busy && !rsp_valid), "block not idle after reset")

endmodule

bind utf8_glyph_lookup glu_checker u_glu_checker (.*);
